>>> rtl/core/pid_line_follow_steer_top_macros.svh
// ----------------------------------------------------------------------------
// pid_line_follow_steer_top_macros.svh
// Assertion macros shared by the steering controller RTL.
// Both macros expect clk and rst to be in scope.
// ----------------------------------------------------------------------------
`ifndef PID_LINE_FOLLOW_STEER_TOP_MACROS_SVH
`define PID_LINE_FOLLOW_STEER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PLFS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pid_line_follow_steer_top: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define PLFS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pid_line_follow_steer_top: next-cycle check failed");

`endif

>>> rtl/core/plfs_pkg.sv
// ----------------------------------------------------------------------------
// plfs_pkg
// Widths, constants, micro-op codes and the control store of the
// line-follower steering controller.
// ----------------------------------------------------------------------------
package plfs_pkg;

  // Fixed-point setup
  localparam int INTEGRAL_WIDTH     = 24;
  localparam int GAIN_FRACTION_BITS = 8;

  // Field widths
  localparam int LEVEL_W = 8;
  localparam int SUM_W   = 10;
  localparam int THR_W   = 10;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 10;
  localparam int QUOT_W  = 8;
  localparam int NUM_W   = 18;
  localparam int DUTY_W  = 8;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 16;
  localparam int CNT_W   = $clog2(QUOT_W);
  localparam int PROD_W  = INTEGRAL_WIDTH + GAIN_W + 1;
  localparam int ACC_W   = PROD_W + 2;
  localparam int PC_W    = 4;

  // Constants of the control law
  localparam int LINE_CENTER = 250;
  localparam int FULL_DUTY   = 255;
  localparam int NODE_DUTY_A = 252;
  localparam int NODE_DUTY_B = 255;

  // Register reset values
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(140);
  localparam logic [GAIN_W-1:0] GAIN_P_RESET    = GAIN_W'(461);
  localparam logic [GAIN_W-1:0] GAIN_I_RESET    = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] GAIN_D_RESET    = GAIN_W'(1216);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_NODE_THRESHOLD    = 2'd0,
    REG_GAIN_PROPORTIONAL = 2'd1,
    REG_GAIN_INTEGRAL     = 2'd2,
    REG_GAIN_DERIVATIVE   = 2'd3
  } reg_idx_t;

  // Micro-operations, one-hot
  typedef enum logic [10:0] {
    OP_LOAD  = 11'b000_0000_0001,
    OP_DIV   = 11'b000_0000_0010,
    OP_PID   = 11'b000_0000_0100,
    OP_MUL_P = 11'b000_0000_1000,
    OP_MUL_I = 11'b000_0001_0000,
    OP_MUL_D = 11'b000_0010_0000,
    OP_ACC   = 11'b000_0100_0000,
    OP_SCALE = 11'b000_1000_0000,
    OP_OUT   = 11'b001_0000_0000,
    OP_NODE  = 11'b010_0000_0000,
    OP_NOP   = 11'b100_0000_0000
  } op_t;

  // Conditions that hold the step counter in place
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_NO_INPUT,
    STALL_OUT_BUSY
  } stall_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JUMP_NONE,
    JUMP_ALWAYS,
    JUMP_IF_NODE,
    JUMP_IF_LOOP
  } jump_t;

  typedef struct packed {
    op_t              op;
    stall_t           stall;
    jump_t            jump;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  // Program addresses
  localparam logic [PC_W-1:0] STEP_LOAD  = 4'd0;
  localparam logic [PC_W-1:0] STEP_DIV   = 4'd1;
  localparam logic [PC_W-1:0] STEP_PID   = 4'd2;
  localparam logic [PC_W-1:0] STEP_MUL_P = 4'd3;
  localparam logic [PC_W-1:0] STEP_MUL_I = 4'd4;
  localparam logic [PC_W-1:0] STEP_MUL_D = 4'd5;
  localparam logic [PC_W-1:0] STEP_ACC   = 4'd6;
  localparam logic [PC_W-1:0] STEP_SCALE = 4'd7;
  localparam logic [PC_W-1:0] STEP_OUT   = 4'd8;
  localparam logic [PC_W-1:0] STEP_NODE  = 4'd9;

  // Control store: one word per step
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      STEP_LOAD:  w = '{OP_LOAD,  STALL_NO_INPUT, JUMP_IF_NODE, STEP_NODE};
      STEP_DIV:   w = '{OP_DIV,   STALL_NONE,     JUMP_IF_LOOP, STEP_DIV};
      STEP_PID:   w = '{OP_PID,   STALL_NONE,     JUMP_NONE,    STEP_LOAD};
      STEP_MUL_P: w = '{OP_MUL_P, STALL_NONE,     JUMP_NONE,    STEP_LOAD};
      STEP_MUL_I: w = '{OP_MUL_I, STALL_NONE,     JUMP_NONE,    STEP_LOAD};
      STEP_MUL_D: w = '{OP_MUL_D, STALL_NONE,     JUMP_NONE,    STEP_LOAD};
      STEP_ACC:   w = '{OP_ACC,   STALL_NONE,     JUMP_NONE,    STEP_LOAD};
      STEP_SCALE: w = '{OP_SCALE, STALL_NONE,     JUMP_NONE,    STEP_LOAD};
      STEP_OUT:   w = '{OP_OUT,   STALL_OUT_BUSY, JUMP_ALWAYS,  STEP_LOAD};
      STEP_NODE:  w = '{OP_NODE,  STALL_OUT_BUSY, JUMP_ALWAYS,  STEP_LOAD};
      default:    w = '{OP_NOP,   STALL_NONE,     JUMP_ALWAYS,  STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/pid_line_follow_steer_top.sv
// ----------------------------------------------------------------------------
// pid_line_follow_steer_top
// Line-follower steering controller: node detector, position estimate by
// restoring division, Q8.8 PID and differential wheel duties.
// ----------------------------------------------------------------------------
// One sensor sample is taken at a time. A sample that reaches the node
// threshold goes from the load step straight to the node step; any other
// sample passes through the load step, eight iterations of the radix-2
// divider loop, the PID update, three passes through the single shared
// multiplier, a final add, the scaling step and the output step. The next
// sample is taken as soon as the sequencer is back at its load step, even
// while the previous result still sits in the output register; the output
// and node steps wait only while that register is full and not taken.
// Configuration writes are always accepted (cfg_ready is tied high).
// ----------------------------------------------------------------------------
`include "pid_line_follow_steer_top_macros.svh"

module pid_line_follow_steer_top (
  input  logic        clk,
  input  logic        rst,
  // Sample input; s_tdata: left_level[7:0], center_level[15:8], right_level[23:16]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  // Result output; m_tdata: channel_a_duty[7:0], channel_b_duty[15:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // m_tuser: node_reached[0]
  output logic        m_tuser,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [plfs_pkg::IDX_W-1:0] cfg_index,
  input  logic [plfs_pkg::CFG_W-1:0] cfg_data
);

  localparam int W   = plfs_pkg::INTEGRAL_WIDTH;
  localparam int EW  = plfs_pkg::ERR_W;
  localparam int PW  = plfs_pkg::PROD_W;
  localparam int AW  = plfs_pkg::ACC_W;
  localparam int DW  = plfs_pkg::DUTY_W;
  localparam int LW  = plfs_pkg::LEVEL_W;
  localparam int SW  = plfs_pkg::SUM_W;
  localparam int QW  = plfs_pkg::QUOT_W;
  localparam int NW  = plfs_pkg::NUM_W;
  localparam int CW  = plfs_pkg::CNT_W;

  localparam logic [DW-1:0] DUTY_FULL   = DW'(plfs_pkg::FULL_DUTY);
  localparam logic [DW-1:0] DUTY_NODE_A = DW'(plfs_pkg::NODE_DUTY_A);
  localparam logic [DW-1:0] DUTY_NODE_B = DW'(plfs_pkg::NODE_DUTY_B);

  // Sequencer
  logic [plfs_pkg::PC_W-1:0] pc;
  logic [plfs_pkg::PC_W-1:0] pc_next;
  plfs_pkg::ctrl_word_t      uw;
  logic                      stalled;
  logic                      exec;
  logic                      jump_taken;

  // Configuration registers
  logic [plfs_pkg::THR_W-1:0]  node_threshold;
  logic [plfs_pkg::GAIN_W-1:0] gain_proportional;
  logic [plfs_pkg::GAIN_W-1:0] gain_integral;
  logic [plfs_pkg::GAIN_W-1:0] gain_derivative;

  // PID state
  logic signed [EW-1:0] previous_error;
  logic signed [W-1:0]  error_integral;

  // Datapath registers
  logic [SW-1:0]        sum;
  logic [SW-1:0]        rem;
  logic [QW-1:0]        qsh;
  logic [CW-1:0]        count;
  logic                 right_weaker;
  logic signed [EW-1:0] deriv;
  logic signed [PW-1:0] product;
  logic signed [AW-1:0] acc;
  logic                 e_neg;
  logic [DW-1:0]        e_mag;

  // Load-step logic
  logic [LW-1:0] left_c;
  logic [LW-1:0] center_c;
  logic [LW-1:0] right_c;
  logic [LW-1:0] side_c;
  logic [SW-1:0] sum_c;
  logic [SW-1:0] pos_num_c;
  logic [NW-1:0] num_c;
  logic          node_c;
  logic          rw_c;

  // Divider step
  logic [SW:0]   div_shift;
  logic [SW+1:0] div_diff;
  logic          div_bit;

  // PID step
  logic signed [EW-1:0] prop_c;
  logic signed [EW-1:0] deriv_c;
  logic [W:0]           int_sum;
  logic [W-1:0]         int_sat;

  // Multiplier and accumulator
  logic signed [W-1:0]             mul_a;
  logic [plfs_pkg::GAIN_W-1:0]     mul_b;
  logic signed [PW-1:0]            mul_p;
  logic signed [AW-1:0]            acc_add;
  logic [AW-1:0]                   acc_mag;
  logic [AW-1:0]                   acc_shift;
  logic [DW-1:0]                   e_mag_c;
  logic [DW-1:0]                   duty_slow;

  assign cfg_ready = 1'b1;
  assign s_tready  = (pc == plfs_pkg::STEP_LOAD);

  // Fetch the control word
  assign uw = plfs_pkg::ucode_rom(pc);

  // Decide whether the current step waits
  always_comb begin
    unique case (uw.stall)
      plfs_pkg::STALL_NONE:     stalled = 1'b0;
      plfs_pkg::STALL_NO_INPUT: stalled = !s_tvalid;
      plfs_pkg::STALL_OUT_BUSY: stalled = m_tvalid && !m_tready;
      default:                  stalled = 1'b0;
    endcase
  end
  assign exec = !stalled;

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.jump)
      plfs_pkg::JUMP_NONE:    jump_taken = 1'b0;
      plfs_pkg::JUMP_ALWAYS:  jump_taken = 1'b1;
      plfs_pkg::JUMP_IF_NODE: jump_taken = node_c;
      plfs_pkg::JUMP_IF_LOOP: jump_taken = (count != CW'(QW - 1));
      default:                jump_taken = 1'b0;
    endcase
  end

  // Advance, jump or hold the step counter
  always_comb begin
    if (!exec) begin
      pc_next = pc;
    end else if (jump_taken) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // Unpack the sample, form the sum, the node flag and the numerator
  always_comb begin
    left_c    = s_tdata[LW-1:0];
    center_c  = s_tdata[2*LW-1:LW];
    right_c   = s_tdata[3*LW-1:2*LW];
    sum_c     = SW'(left_c) + SW'(center_c) + SW'(right_c);
    node_c    = (sum_c >= node_threshold);
    rw_c      = (right_c <= left_c);
    side_c    = rw_c ? right_c : left_c;
    pos_num_c = (SW'(side_c) << 1) + SW'(center_c);
    num_c     = NW'(pos_num_c) * NW'(plfs_pkg::LINE_CENTER);
  end

  // One restoring division step
  always_comb begin
    div_shift = {rem, qsh[QW-1]};
    div_diff  = {1'b0, div_shift} - {2'b00, sum};
    div_bit   = !div_diff[SW+1];
  end

  // Error, saturating integral and difference
  always_comb begin
    if (sum == '0) begin
      prop_c = '0;
    end else begin
      prop_c = EW'(qsh) - EW'(plfs_pkg::LINE_CENTER);
    end
    deriv_c = prop_c - previous_error;
    int_sum = {error_integral[W-1], error_integral}
            + {{(W + 1 - EW){prop_c[EW-1]}}, prop_c};
    if (int_sum[W] != int_sum[W-1]) begin
      int_sat = int_sum[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    end else begin
      int_sat = int_sum[W-1:0];
    end
  end

  // Select the multiplier operands
  always_comb begin
    unique case (uw.op)
      plfs_pkg::OP_MUL_P: begin
        mul_a = {{(W - EW){previous_error[EW-1]}}, previous_error};
        mul_b = gain_proportional;
      end
      plfs_pkg::OP_MUL_I: begin
        mul_a = error_integral;
        mul_b = gain_integral;
      end
      plfs_pkg::OP_MUL_D: begin
        mul_a = {{(W - EW){deriv[EW-1]}}, deriv};
        mul_b = gain_derivative;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p   = mul_a * $signed({1'b0, mul_b});
  assign acc_add = acc + {{(AW - PW){product[PW-1]}}, product};

  // Truncate toward zero and clamp the magnitude
  always_comb begin
    acc_mag   = acc[AW-1] ? (~acc + 1'b1) : acc;
    acc_shift = acc_mag >> plfs_pkg::GAIN_FRACTION_BITS;
    if (acc_shift > AW'(plfs_pkg::FULL_DUTY)) begin
      e_mag_c = DW'(plfs_pkg::FULL_DUTY);
    end else begin
      e_mag_c = acc_shift[DW-1:0];
    end
    duty_slow = DW'(plfs_pkg::FULL_DUTY) - e_mag;
  end

  // Control state: step counter, configuration, PID state, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pc                <= plfs_pkg::STEP_LOAD;
      m_tvalid          <= 1'b0;
      node_threshold    <= plfs_pkg::THRESHOLD_RESET;
      gain_proportional <= plfs_pkg::GAIN_P_RESET;
      gain_integral     <= plfs_pkg::GAIN_I_RESET;
      gain_derivative   <= plfs_pkg::GAIN_D_RESET;
      previous_error    <= '0;
      error_integral    <= '0;
    end else begin
      pc <= pc_next;

      // Take configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (plfs_pkg::reg_idx_t'(cfg_index))
          plfs_pkg::REG_NODE_THRESHOLD:
            node_threshold <= cfg_data[plfs_pkg::THR_W-1:0];
          plfs_pkg::REG_GAIN_PROPORTIONAL: gain_proportional <= cfg_data;
          plfs_pkg::REG_GAIN_INTEGRAL:     gain_integral     <= cfg_data;
          plfs_pkg::REG_GAIN_DERIVATIVE:   gain_derivative   <= cfg_data;
          default: ;
        endcase
      end

      // Update or clear the PID state
      if (exec && uw.op == plfs_pkg::OP_PID) begin
        previous_error <= prop_c;
        error_integral <= int_sat;
      end else if (exec && uw.op == plfs_pkg::OP_NODE) begin
        previous_error <= '0;
        error_integral <= '0;
      end

      // Raise valid on a new result, drop it once the result is taken
      if (exec && (uw.op == plfs_pkg::OP_OUT || uw.op == plfs_pkg::OP_NODE)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers driven by the micro-op
  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (uw.op)
        plfs_pkg::OP_LOAD: begin
          sum          <= sum_c;
          right_weaker <= rw_c;
          rem          <= num_c[NW-1:QW];
          qsh          <= num_c[QW-1:0];
          count        <= '0;
        end
        plfs_pkg::OP_DIV: begin
          rem   <= div_bit ? div_diff[SW-1:0] : div_shift[SW-1:0];
          qsh   <= {qsh[QW-2:0], div_bit};
          count <= count + 1'b1;
        end
        plfs_pkg::OP_PID: begin
          deriv <= deriv_c;
        end
        plfs_pkg::OP_MUL_P: begin
          product <= mul_p;
          acc     <= '0;
        end
        plfs_pkg::OP_MUL_I, plfs_pkg::OP_MUL_D: begin
          product <= mul_p;
          acc     <= acc_add;
        end
        plfs_pkg::OP_ACC: begin
          acc <= acc_add;
        end
        plfs_pkg::OP_SCALE: begin
          e_neg <= acc[AW-1];
          e_mag <= e_mag_c;
        end
        plfs_pkg::OP_OUT: begin
          m_tuser <= 1'b0;
          // Slow channel A when the steering side matches the error sign
          if (right_weaker == e_neg) begin
            m_tdata <= {DW'(plfs_pkg::FULL_DUTY), duty_slow};
          end else begin
            m_tdata <= {duty_slow, DW'(plfs_pkg::FULL_DUTY)};
          end
        end
        plfs_pkg::OP_NODE: begin
          m_tuser <= 1'b1;
          m_tdata <= {DW'(plfs_pkg::NODE_DUTY_B), DW'(plfs_pkg::NODE_DUTY_A)};
        end
        default: ;
      endcase
    end
  end

  // Checks
  `PLFS_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready)
  `PLFS_ASSERT_IMP(a_node_duties, m_tvalid && m_tuser, m_tdata == {DUTY_NODE_B, DUTY_NODE_A})
  `PLFS_ASSERT_IMP(a_one_wheel_full, m_tvalid && !m_tuser, m_tdata[7:0] == DUTY_FULL || m_tdata[15:8] == DUTY_FULL)
  `PLFS_ASSERT_IMP(a_error_not_positive, 1'b1, previous_error[EW-1] || previous_error == '0)
  `PLFS_ASSERT_NEXT(a_node_clears_state, exec && uw.op == plfs_pkg::OP_NODE, previous_error == '0 && error_integral == '0)

endmodule
